/* rtl/lexcls_pkg.sv */
`timescale 1ns / 1ps

package lexcls_pkg;

  localparam int LEXEME_BUFFER_BYTES_DEF = 128;
  localparam int CP_W = 21;
  localparam int CFG_DATA_W = 8;
  localparam int TAB_W = 5;
  localparam int POS_W = 16;

  localparam logic [4:0] TAB_WIDTH_RST = 5'd4;
  localparam logic [7:0] MAX_LEXEME_RST = 8'd127;

  localparam logic [CP_W-1:0] CH_TAB        = 21'h09;
  localparam logic [CP_W-1:0] CH_LF         = 21'h0A;
  localparam logic [CP_W-1:0] CH_CR         = 21'h0D;
  localparam logic [CP_W-1:0] CH_SPACE      = 21'h20;
  localparam logic [CP_W-1:0] CH_QUOTE      = 21'h22;
  localparam logic [CP_W-1:0] CH_PERCENT    = 21'h25;
  localparam logic [CP_W-1:0] CH_DOT        = 21'h2E;
  localparam logic [CP_W-1:0] CH_SLASH      = 21'h2F;
  localparam logic [CP_W-1:0] CH_UNDERSCORE = 21'h5F;

  typedef enum logic [0:0] {
    REG_TAB_WIDTH  = 1'b0,
    REG_MAX_LEXEME = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_SPACE        = 3'd0,
    KIND_COMMENT      = 3'd1,
    KIND_IDENT        = 3'd2,
    KIND_NUMBER       = 3'd3,
    KIND_STRING       = 3'd4,
    KIND_DELIM        = 3'd5,
    KIND_INVALID      = 3'd6,
    KIND_UNTERMINATED = 3'd7
  } kind_t;

  typedef enum logic [7:0] {
    MODE_IDLE          = 8'b0000_0001,
    MODE_LINE_COMMENT  = 8'b0000_0010,
    MODE_BLOCK_OPEN    = 8'b0000_0100,
    MODE_BLOCK_BODY    = 8'b0000_1000,
    MODE_BLOCK_CLOSE   = 8'b0001_0000,
    MODE_IDENT         = 8'b0010_0000,
    MODE_NUMBER        = 8'b0100_0000,
    MODE_STRING        = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic [2:0]      byte_count;
    logic            last;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]  char_out;
    logic [2:0]       kind;
    logic             token_start;
    logic             token_end;
    logic             kept;
    logic [POS_W-1:0] line_no;
    logic [POS_W-1:0] column_no;
    logic             final_res;
  } out_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       token_start;
    logic       token_end;
    logic       lexeme;
  } scan_info_t;

  function automatic logic is_break(input logic [CP_W-1:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_space(input logic [CP_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || is_break(c);
  endfunction

  function automatic logic is_digit(input logic [CP_W-1:0] c);
    return (c >= 21'h30) && (c <= 21'h39);
  endfunction

  function automatic logic is_letter(input logic [CP_W-1:0] c);
    return ((c >= 21'h61) && (c <= 21'h7A)) || ((c >= 21'h41) && (c <= 21'h5A)) ||
           (c == 21'hC5) || (c == 21'hC4) || (c == 21'hD6) ||
           (c == 21'hE5) || (c == 21'hE4) || (c == 21'hF6);
  endfunction

  function automatic logic is_ident_tail(input logic [CP_W-1:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_delim(input logic [CP_W-1:0] c);
    return (c == 21'h3B) || (c == 21'h2C) || (c == 21'h3A) || (c == 21'h28) ||
           (c == 21'h29) || (c == 21'h3C) || (c == 21'h3E) || (c == CH_DOT) ||
           (c == 21'h2B) || (c == 21'h2D) || (c == 21'h2A) || (c == CH_SLASH);
  endfunction

endpackage

/* rtl/lexcls_scan.sv */
`timescale 1ns / 1ps

module lexcls_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    clear,
  input  logic [lexcls_pkg::CP_W-1:0] c,
  input  logic                    has_next,
  input  logic [lexcls_pkg::CP_W-1:0] nx,
  output lexcls_pkg::scan_info_t  info
);
  import lexcls_pkg::*;

  mode_t mode;
  mode_t mode_next;
  logic  nx_tail;
  logic  nx_num;
  logic  nx_closes_string;

  assign nx_tail          = has_next && is_ident_tail(nx);
  assign nx_num           = has_next && (is_digit(nx) || (nx == CH_DOT));
  assign nx_closes_string = !has_next || is_break(nx);

  always_comb begin
    mode_next        = mode;
    info.kind        = KIND_INVALID;
    info.token_start = 1'b0;
    info.token_end   = 1'b0;
    info.lexeme      = 1'b0;
    unique case (mode)
      MODE_LINE_COMMENT: begin
        info.kind = KIND_COMMENT;
        if (is_break(c)) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_BLOCK_OPEN: begin
        info.kind = KIND_COMMENT;
        mode_next = MODE_BLOCK_BODY;
      end
      MODE_BLOCK_BODY: begin
        info.kind = KIND_COMMENT;
        if ((c == CH_PERCENT) && has_next && (nx == CH_SLASH)) begin
          mode_next = MODE_BLOCK_CLOSE;
        end
      end
      MODE_BLOCK_CLOSE: begin
        info.kind = KIND_COMMENT;
        mode_next = MODE_IDLE;
      end
      MODE_IDENT: begin
        info.kind   = KIND_IDENT;
        info.lexeme = 1'b1;
        if (!nx_tail) begin
          info.token_end = 1'b1;
          mode_next      = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        info.kind   = KIND_NUMBER;
        info.lexeme = 1'b1;
        if (!nx_num) begin
          info.token_end = 1'b1;
          mode_next      = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        info.kind   = KIND_STRING;
        info.lexeme = 1'b1;
        if (c == CH_QUOTE) begin
          info.token_end = 1'b1;
          mode_next      = MODE_IDLE;
        end else if (nx_closes_string) begin
          info.kind      = KIND_UNTERMINATED;
          info.token_end = 1'b1;
          mode_next      = MODE_IDLE;
        end
      end
      default: begin
        if (is_space(c)) begin
          info.kind = KIND_SPACE;
        end else if ((c == CH_SLASH) && has_next && (nx == CH_SLASH)) begin
          info.kind = KIND_COMMENT;
          mode_next = MODE_LINE_COMMENT;
        end else if ((c == CH_SLASH) && has_next && (nx == CH_PERCENT)) begin
          info.kind = KIND_COMMENT;
          mode_next = MODE_BLOCK_OPEN;
        end else if (is_letter(c)) begin
          info.kind        = KIND_IDENT;
          info.token_start = 1'b1;
          info.lexeme      = 1'b1;
          if (nx_tail) begin
            mode_next = MODE_IDENT;
          end else begin
            info.token_end = 1'b1;
          end
        end else if (c == CH_QUOTE) begin
          info.kind        = KIND_STRING;
          info.token_start = 1'b1;
          info.lexeme      = 1'b1;
          if (nx_closes_string) begin
            info.kind      = KIND_UNTERMINATED;
            info.token_end = 1'b1;
          end else begin
            mode_next = MODE_STRING;
          end
        end else if (is_digit(c)) begin
          info.kind        = KIND_NUMBER;
          info.token_start = 1'b1;
          info.lexeme      = 1'b1;
          if (nx_num) begin
            mode_next = MODE_NUMBER;
          end else begin
            info.token_end = 1'b1;
          end
        end else if (is_delim(c)) begin
          info.kind        = KIND_DELIM;
          info.token_start = 1'b1;
          info.token_end   = 1'b1;
          info.lexeme      = 1'b1;
        end else begin
          info.kind = KIND_INVALID;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (step) begin
      mode <= clear ? MODE_IDLE : mode_next;
    end
  end

endmodule

/* rtl/lexcls_track.sv */
`timescale 1ns / 1ps

module lexcls_track #(
  parameter int LexemeBufferBytes = lexcls_pkg::LEXEME_BUFFER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         clear,
  input  logic [lexcls_pkg::CP_W-1:0]  c,
  input  logic [2:0]                   bytes,
  input  lexcls_pkg::scan_info_t       info,
  input  logic [lexcls_pkg::TAB_W-1:0] tab_width,
  input  logic [7:0]                   max_lexeme_bytes,
  output logic                         kept,
  output logic [lexcls_pkg::POS_W-1:0] row,
  output logic [lexcls_pkg::POS_W-1:0] col
);
  import lexcls_pkg::*;

  localparam logic [7:0] BufLimit = 8'(LexemeBufferBytes - 1);

  logic [7:0]       fill;
  logic [7:0]       fill_next;
  logic [7:0]       lim;
  logic [7:0]       base;
  logic [8:0]       sum;
  logic [POS_W-1:0] col_step;
  logic [POS_W:0]   col_sum;
  logic [POS_W:0]   row_sum;
  logic [POS_W-1:0] row_next;
  logic [POS_W-1:0] col_next;

  assign lim       = (max_lexeme_bytes > BufLimit) ? BufLimit : max_lexeme_bytes;
  assign base      = info.token_start ? 8'd0 : fill;
  assign sum       = {1'b0, base} + {6'b0, bytes};
  assign kept      = info.lexeme && (sum <= {1'b0, lim});
  assign fill_next = !info.lexeme ? fill : (sum[8] ? 8'hFF : sum[7:0]);

  assign col_step = (c == CH_TAB) ? {{(POS_W-TAB_W){1'b0}}, tab_width} : POS_W'(1);
  assign col_sum  = {1'b0, col} + {1'b0, col_step};
  assign row_sum  = {1'b0, row} + (POS_W+1)'(1);

  always_comb begin
    if (is_break(c)) begin
      row_next = row_sum[POS_W] ? {POS_W{1'b1}} : row_sum[POS_W-1:0];
      col_next = POS_W'(1);
    end else begin
      row_next = row;
      col_next = col_sum[POS_W] ? {POS_W{1'b1}} : col_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      row  <= POS_W'(1);
      col  <= POS_W'(1);
      fill <= 8'd0;
    end else if (step) begin
      row  <= row_next;
      col  <= col_next;
      fill <= fill_next;
    end
  end

endmodule

/* rtl/source_lexer_char_classifier_unit.sv */
`timescale 1ns / 1ps

// Classifies a source text one code point per clock. Each character is held
// as lookahead, and its result is loaded into the output register in the
// cycle its successor is accepted; a character marked last gets its result
// at the first edge after it is accepted at which the output register is
// free, so a stream of N characters gives N result beats, and a new stream
// may start in the cycle the last result is loaded. Input is taken every
// cycle unless a character is held and the output register is full and not
// being taken. After the last result the mode, row, column and lexeme fill
// return to their reset values; tab width and lexeme limit stay as written.
module source_lexer_char_classifier_unit #(
  parameter int LEXEME_BUFFER_BYTES = lexcls_pkg::LEXEME_BUFFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lexcls_pkg::in_beat_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lexcls_pkg::out_beat_t             out_data,
  input  logic                              cfg_write,
  input  logic [0:0]                        cfg_index,
  input  logic [lexcls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lexcls_pkg::*;

  logic [CP_W-1:0]  held_char;
  logic [2:0]       held_bytes;
  logic             held_last;
  logic             held_valid;
  logic [TAB_W-1:0] tab_width;
  logic [7:0]       max_lexeme_bytes;

  logic             in_fire;
  logic             out_can_load;
  logic             step;
  scan_info_t       info;
  logic             kept;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;

  assign out_can_load = !out_valid || out_ready;
  assign in_ready     = !held_valid || out_can_load;
  assign in_fire      = in_valid && in_ready;
  assign step         = held_valid && out_can_load && (held_last || in_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width        <= TAB_WIDTH_RST;
      max_lexeme_bytes <= MAX_LEXEME_RST;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_TAB_WIDTH:  tab_width        <= cfg_data[TAB_W-1:0];
        REG_MAX_LEXEME: max_lexeme_bytes <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_fire) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_char  <= in_data.codepoint;
      held_bytes <= in_data.byte_count;
      held_last  <= in_data.last;
    end
  end

  lexcls_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .clear    (held_last),
    .c        (held_char),
    .has_next (!held_last),
    .nx       (in_data.codepoint),
    .info     (info)
  );

  lexcls_track #(
    .LexemeBufferBytes (LEXEME_BUFFER_BYTES)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .clear            (held_last),
    .c                (held_char),
    .bytes            (held_bytes),
    .info             (info),
    .tab_width        (tab_width),
    .max_lexeme_bytes (max_lexeme_bytes),
    .kept             (kept),
    .row              (row),
    .col              (col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.char_out    <= held_char;
      out_data.kind        <= info.kind;
      out_data.token_start <= info.token_start;
      out_data.token_end   <= info.token_end;
      out_data.kept        <= kept;
      out_data.line_no     <= row;
      out_data.column_no   <= col;
      out_data.final_res   <= held_last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !step)
    else $error("result loaded over a stalled beat");

  a_lookahead_release: assert property (@(posedge clk) disable iff (rst)
    (in_fire && held_valid) |-> step)
    else $error("held character not released on new beat");

  a_start_is_lexeme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.token_start) |->
      (out_data.kind == KIND_IDENT || out_data.kind == KIND_NUMBER ||
       out_data.kind == KIND_STRING || out_data.kind == KIND_DELIM ||
       out_data.kind == KIND_UNTERMINATED))
    else $error("token start on a non-lexeme kind");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (step && held_last) |=> (out_valid && out_data.final_res))
    else $error("last character did not produce a final beat");

endmodule
